### design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Simulation gets concurrent assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on each clock edge, skipped while rst is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("box blur assertion failed");
// Check prop on each clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("box blur assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### design/bbr_pkg.sv
// Shared types and constants of the 3x3 box blur.
// No dependencies; imported by the top level, bbr_front and bbr_back.
package bbr_pkg;

  localparam int MAX_WIDTH_DEF      = 512;
  localparam int MAX_HEIGHT         = 512;
  localparam int ROW_W              = $clog2(MAX_HEIGHT);
  localparam int CFG_W              = 10;
  localparam int CFG_IDX_W          = 1;
  localparam int FRAME_WIDTH_RESET  = 512;
  localparam int FRAME_HEIGHT_RESET = 512;
  localparam int CSUM_W             = 10;
  localparam int SUM_W              = 12;
  localparam int MID_DEPTH          = 4;
  localparam int OUT_DEPTH          = 4;
  localparam int MID_CNT_W          = $clog2(MID_DEPTH + 1);
  localparam int OUT_CNT_W          = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [CSUM_W-1:0] r;
    logic [CSUM_W-1:0] g;
    logic [CSUM_W-1:0] b;
  } csum_t;

  // Entry from front to back: a pass pixel or three column sums to average.
  typedef struct packed {
    logic        is_mean;
    logic        frame_end;
    rgb_t        pix;
    csum_t [2:0] col;
  } mid_t;

  typedef struct packed {
    logic frame_end;
    rgb_t pix;
  } out_t;

endpackage

### design/box_blur_3x3_rgb.sv
// Top level of the 3x3 RGB box blur: front, middle queue, back, result queue.
// Depends on bbr_pkg, bbr_front, bbr_back, bbr_fifo and assert_macros.svh.
//
//  Channel  Handshake     Fields
//  cfg      cfg_we        cfg_index, cfg_wdata
//  in       push / full   func, red_in, green_in, blue_in
//  out      empty / pop   red_out, green_out, blue_out, frame_end
//
// One item per clock sustained while full stays low; a result passes through the
// line store read, window update, sum, divide and queue after its item.
// Reset clears counters, window and queues; the line stores are not cleared.
// A frame_height write holds full high while the row remainder unit works
// one bit per cycle. With pop low, up to eight results are held
// in the two queues before full rises.
`include "assert_macros.svh"

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic [7:0]                    red_in,
  input  logic [7:0]                    green_in,
  input  logic [7:0]                    blue_in,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    red_out,
  output logic [7:0]                    green_out,
  output logic [7:0]                    blue_out,
  output logic                          frame_end
);
  import bbr_pkg::*;

  rgb_t                 pix_in;
  logic                 mid_push;
  mid_t                 mid_wr;
  logic [$bits(mid_t)-1:0] mid_rd_bits;
  mid_t                 mid_rd;
  logic                 mid_pop;
  logic                 mid_empty;
  logic [MID_CNT_W-1:0] mid_count;
  logic                 out_push;
  out_t                 out_wr;
  logic [$bits(out_t)-1:0] out_rd_bits;
  out_t                 out_rd;
  logic                 out_pop;
  logic [OUT_CNT_W-1:0] out_count;

  assign pix_in = {red_in, green_in, blue_in};

  bbr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .func      (func),
    .pix_in    (pix_in),
    .mid_count (mid_count),
    .mid_push  (mid_push),
    .mid_data  (mid_wr)
  );

  bbr_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_wr),
    .pop     (mid_pop),
    .rd_data (mid_rd_bits),
    .empty   (mid_empty),
    .count   (mid_count)
  );

  assign mid_rd = mid_t'(mid_rd_bits);

  bbr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_rd),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_data  (out_wr)
  );

  assign out_pop = pop && !empty;

  bbr_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (out_push),
    .wr_data (out_wr),
    .pop     (out_pop),
    .rd_data (out_rd_bits),
    .empty   (empty),
    .count   (out_count)
  );

  assign out_rd    = out_t'(out_rd_bits);
  assign red_out   = out_rd.pix.r;
  assign green_out = out_rd.pix.g;
  assign blue_out  = out_rd.pix.b;
  assign frame_end = out_rd.frame_end;

  `ASSERT_CLK(mid_q_no_overflow, clk, rst, mid_push |-> 32'(mid_count) < MID_DEPTH)
  `ASSERT_CLK(out_q_no_overflow, clk, rst, out_push |-> 32'(out_count) < OUT_DEPTH)
  `ASSERT_CLK(height_write_stalls, clk, rst, cfg_we && cfg_index == REG_FRAME_HEIGHT |=> full)
  `ASSERT_ALWAYS(empty_after_reset, clk, rst |=> empty)

endmodule

### design/bbr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/bbr_fifo.sv
// Small register queue with occupancy count.
// No dependencies; used between front and back and at the result side.
module bbr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/bbr_front.sv
// Front of the box blur: config, position counters, classification,
// line stores and the 3x3 window. Depends on bbr_pkg and bbr_ram.
module bbr_front #(
  parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbr_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           push,
  output logic                           full,
  input  logic                           func,
  input  bbr_pkg::rgb_t                  pix_in,
  input  logic [bbr_pkg::MID_CNT_W-1:0]  mid_count,
  output logic                           mid_push,
  output bbr_pkg::mid_t                  mid_data
);
  import bbr_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int STEP_W = $clog2(ROW_W);
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    KIND_CENTER,
    KIND_MEAN,
    KIND_STORE_A,
    KIND_STORE_B
  } kind_t;

  function automatic logic [COL_W-1:0] width_last(input logic [CFG_W-1:0] v);
    if (v < CFG_W'(3)) return COL_W'(2);
    else if (32'(v) > MAX_WIDTH) return COL_W'(MAX_WIDTH - 1);
    else return COL_W'(v - CFG_W'(1));
  endfunction

  function automatic logic [ROW_W-1:0] height_last(input logic [CFG_W-1:0] v);
    if (v < CFG_W'(3)) return ROW_W'(2);
    else if (32'(v) > MAX_HEIGHT) return ROW_W'(MAX_HEIGHT - 1);
    else return ROW_W'(v - CFG_W'(1));
  endfunction

  // Config and counters
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [ROW_W-1:0]  in_row_m;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;

  // Row remainder unit
  logic              mod_busy;
  logic [STEP_W-1:0] mod_step;
  logic [ROW_W-1:0]  mod_rem;
  logic [ROW_W:0]    mod_shift;
  logic [ROW_W:0]    h_full;
  logic [ROW_W-1:0]  mod_rem_next;

  // Stage 0
  logic              accept;
  logic              is_drain;
  logic              in_start;
  logic              out_start;
  logic [1:0]        dr;
  logic [COL_W-1:0]  lc;
  logic [ROW_W:0]    lr_wrap;
  logic [ROW_W-1:0]  lr;
  logic              frame_last;
  logic              on_border;
  logic              emit;
  kind_t             kind;
  logic [COL_W-1:0]  rd_addr;
  logic              fwd;
  logic [COL_W-1:0]  in_col_next;
  logic [ROW_W-1:0]  in_row_next;
  logic [COL_W-1:0]  out_col_next;
  logic [ROW_W-1:0]  out_row_next;
  logic              pend;

  // Stage 1
  logic              s1_valid;
  logic              s1_pixel;
  logic              s1_emit;
  kind_t             s1_kind;
  logic              s1_frame_end;
  logic [COL_W-1:0]  s1_col;
  rgb_t              s1_pix;
  logic              s1_fwd;
  rgb_t              fwd_a;
  rgb_t              fwd_b;
  logic [23:0]       ram_a_q;
  logic [23:0]       ram_b_q;
  rgb_t              a_rd;
  rgb_t              b_rd;
  logic              s1_write;
  csum_t             new_col;
  csum_t [2:0]       win_cs;
  rgb_t              win_mid;

  assign pend   = s1_valid && s1_emit;
  assign full   = mod_busy || ((32'(mid_count) + 32'(pend)) >= MID_DEPTH);
  assign accept = push && !full;

  assign h_full       = (ROW_W+1)'(h_last) + (ROW_W+1)'(1);
  assign mod_shift    = {mod_rem, in_row[mod_step]};
  assign mod_rem_next = (mod_shift >= h_full) ? ROW_W'(mod_shift - h_full)
                                              : ROW_W'(mod_shift);

  always_comb begin
    is_drain   = (func == FUNC_DRAIN);
    in_start   = (in_col == '0) && (in_row == '0);
    out_start  = (out_col == '0) && (out_row == '0);
    dr         = (in_col == '0) ? 2'd2 : 2'd1;
    lc         = (in_col == '0) ? w_last : in_col - COL_W'(1);
    lr_wrap    = (ROW_W+1)'(in_row_m) + h_full - (ROW_W+1)'(dr);
    lr         = (in_row_m >= ROW_W'(dr)) ? in_row_m - ROW_W'(dr) : lr_wrap[ROW_W-1:0];
    frame_last = (out_row == h_last) && (out_col == w_last);
    on_border  = (out_row == '0) || (out_col == '0) ||
                 (out_row >= h_last) || (out_col >= w_last);
    if (is_drain) begin
      emit = in_start && !out_start;
      kind = (out_row == h_last) ? KIND_STORE_A : KIND_STORE_B;
    end else begin
      emit = (lc == out_col) && (lr == out_row);
      kind = on_border ? KIND_CENTER : KIND_MEAN;
    end
    rd_addr = is_drain ? out_col : in_col;
    fwd     = s1_valid && s1_pixel && (s1_col == rd_addr);

    if (in_col >= w_last) begin
      in_col_next = '0;
      in_row_next = (in_row >= h_last) ? '0 : in_row + ROW_W'(1);
    end else begin
      in_col_next = in_col + COL_W'(1);
      in_row_next = in_row;
    end
    if (out_col >= w_last) begin
      out_col_next = '0;
      out_row_next = (out_row >= h_last) ? '0 : out_row + ROW_W'(1);
    end else begin
      out_col_next = out_col + COL_W'(1);
      out_row_next = out_row;
    end
  end

  bbr_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_col),
    .wdata (s1_pix),
    .raddr (rd_addr),
    .rdata (ram_a_q)
  );

  bbr_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1_col),
    .wdata (a_rd),
    .raddr (rd_addr),
    .rdata (ram_b_q)
  );

  assign s1_write = s1_valid && s1_pixel;
  assign a_rd     = s1_fwd ? fwd_a : rgb_t'(ram_a_q);
  assign b_rd     = s1_fwd ? fwd_b : rgb_t'(ram_b_q);

  always_comb begin
    new_col.r = CSUM_W'(b_rd.r) + CSUM_W'(a_rd.r) + CSUM_W'(s1_pix.r);
    new_col.g = CSUM_W'(b_rd.g) + CSUM_W'(a_rd.g) + CSUM_W'(s1_pix.g);
    new_col.b = CSUM_W'(b_rd.b) + CSUM_W'(a_rd.b) + CSUM_W'(s1_pix.b);

    mid_data.is_mean   = (s1_kind == KIND_MEAN);
    mid_data.frame_end = s1_frame_end;
    mid_data.col       = {new_col, win_cs[2], win_cs[1]};
    unique case (s1_kind)
      KIND_STORE_A: mid_data.pix = a_rd;
      KIND_STORE_B: mid_data.pix = b_rd;
      KIND_CENTER:  mid_data.pix = win_mid;
      KIND_MEAN:    mid_data.pix = win_mid;
    endcase
  end

  assign mid_push = s1_valid && s1_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last   <= width_last(CFG_W'(FRAME_WIDTH_RESET));
      h_last   <= height_last(CFG_W'(FRAME_HEIGHT_RESET));
      in_col   <= '0;
      in_row   <= '0;
      in_row_m <= '0;
      out_col  <= '0;
      out_row  <= '0;
      mod_busy <= 1'b0;
      mod_step <= '0;
      mod_rem  <= '0;
      s1_valid <= 1'b0;
      win_cs   <= '0;
      win_mid  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  w_last <= width_last(cfg_wdata);
          REG_FRAME_HEIGHT: h_last <= height_last(cfg_wdata);
        endcase
      end
      // Reduce the input row modulo the new height, one bit per cycle
      if (cfg_we && cfg_index == REG_FRAME_HEIGHT) begin
        mod_busy <= 1'b1;
        mod_step <= STEP_W'(ROW_W - 1);
        mod_rem  <= '0;
      end else if (mod_busy) begin
        mod_rem <= mod_rem_next;
        if (mod_step == '0) begin
          mod_busy <= 1'b0;
          in_row_m <= mod_rem_next;
        end else begin
          mod_step <= mod_step - STEP_W'(1);
        end
      end

      if (accept) begin
        if (!is_drain) begin
          in_col   <= in_col_next;
          in_row   <= in_row_next;
          in_row_m <= in_row_next;
        end
        if (emit) begin
          out_col <= out_col_next;
          out_row <= out_row_next;
        end
      end
      s1_valid <= accept;

      if (s1_write) begin
        win_cs  <= {new_col, win_cs[2], win_cs[1]};
        win_mid <= a_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pixel     <= !is_drain;
    s1_emit      <= emit;
    s1_kind      <= kind;
    s1_frame_end <= frame_last;
    s1_col       <= in_col;
    s1_pix       <= pix_in;
    s1_fwd       <= fwd;
    fwd_a        <= s1_pix;
    fwd_b        <= a_rd;
  end

endmodule

### design/bbr_back.sv
// Back of the box blur: nine-pixel sum and divide by nine per channel for mean
// entries; other entries pass their pixel through. Depends on bbr_pkg.
module bbr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mid_empty,
  input  bbr_pkg::mid_t                 mid_data,
  output logic                          mid_pop,
  input  logic [bbr_pkg::OUT_CNT_W-1:0] out_count,
  output logic                          out_push,
  output bbr_pkg::out_t                 out_data
);
  import bbr_pkg::*;

  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_9     = (1 << RECIP_SHIFT) / 9 + 1;
  localparam int PROD_W      = SUM_W + RECIP_SHIFT - 2;

  // Multiply by a rounded-up reciprocal; exact floor for sums up to 9 * 255.
  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(RECIP_9);
    return p[RECIP_SHIFT +: 8];
  endfunction

  logic             room;
  logic             a_valid;
  logic             a_is_mean;
  logic             a_frame_end;
  rgb_t             a_pix;
  logic [SUM_W-1:0] a_sum_r;
  logic [SUM_W-1:0] a_sum_g;
  logic [SUM_W-1:0] a_sum_b;
  logic             b_valid;
  out_t             b_data;
  rgb_t             mean_pix;

  assign room    = (32'(out_count) + 32'(a_valid) + 32'(b_valid)) < OUT_DEPTH;
  assign mid_pop = !mid_empty && room;

  always_comb begin
    mean_pix.r = div9(a_sum_r);
    mean_pix.g = div9(a_sum_g);
    mean_pix.b = div9(a_sum_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= mid_pop;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_is_mean   <= mid_data.is_mean;
    a_frame_end <= mid_data.frame_end;
    a_pix       <= mid_data.pix;
    a_sum_r     <= SUM_W'(mid_data.col[0].r) + SUM_W'(mid_data.col[1].r) +
                   SUM_W'(mid_data.col[2].r);
    a_sum_g     <= SUM_W'(mid_data.col[0].g) + SUM_W'(mid_data.col[1].g) +
                   SUM_W'(mid_data.col[2].g);
    a_sum_b     <= SUM_W'(mid_data.col[0].b) + SUM_W'(mid_data.col[1].b) +
                   SUM_W'(mid_data.col[2].b);
    b_data.frame_end <= a_frame_end;
    b_data.pix       <= a_is_mean ? mean_pix : a_pix;
  end

  assign out_push = b_valid;
  assign out_data = b_data;

endmodule
